// File: src/x86enc_pkg.sv
// ----------------------------------------------------------------------------
// x86enc_pkg
// Types, operation codes and opcode tables for the x86-64 instruction encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package x86enc_pkg;

  localparam int unsigned MaxBytes = 11;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  // operation codes
  localparam logic [4:0] OP_MOV     = 5'd0;
  localparam logic [4:0] OP_LEA     = 5'd1;
  localparam logic [4:0] OP_XOR     = 5'd9;
  localparam logic [4:0] OP_NEG     = 5'd10;
  localparam logic [4:0] OP_PUSH    = 5'd11;
  localparam logic [4:0] OP_POP     = 5'd12;
  localparam logic [4:0] OP_NOP     = 5'd13;
  localparam logic [4:0] OP_SYSCALL = 5'd14;
  localparam logic [4:0] OP_CDQ     = 5'd15;
  localparam logic [4:0] OP_CQO     = 5'd16;
  localparam logic [4:0] OP_LEAVE   = 5'd17;
  localparam logic [4:0] OP_RET     = 5'd18;
  localparam logic [4:0] OP_RET_IMM = 5'd19;

  // operand kinds
  localparam logic       KIND_REG  = 1'b0;
  localparam logic       KIND_MEM  = 1'b1;
  localparam logic [1:0] SRC_REG   = 2'd0;
  localparam logic [1:0] SRC_MEM   = 2'd1;
  localparam logic [1:0] SRC_IMM   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SIZE     = 2'd1;
  localparam logic [1:0] ST_BASE     = 2'd2;
  localparam logic [1:0] ST_STACK_SZ = 2'd3;

  // fixed bytes
  localparam logic [7:0] B_REXW    = 8'h48;
  localparam logic [7:0] B_IMM8    = 8'h83;
  localparam logic [7:0] B_IMM32   = 8'h81;
  localparam logic [7:0] B_GRP3    = 8'hf7;
  localparam logic [7:0] B_MOVRI   = 8'hb8;
  localparam logic [7:0] B_MOVMI   = 8'hc7;
  localparam logic [7:0] B_NOP     = 8'h90;
  localparam logic [7:0] B_RETI    = 8'hc2;
  localparam logic [7:0] B_RET     = 8'hc3;
  localparam logic [7:0] B_LEAVE   = 8'hc9;
  localparam logic [7:0] B_CDQ     = 8'h99;
  localparam logic [7:0] B_ESC     = 8'h0f;
  localparam logic [7:0] B_SYSCALL = 8'h05;
  localparam logic [7:0] B_PUSH    = 8'h50;
  localparam logic [7:0] B_POP     = 8'h58;
  localparam logic [7:0] B_NEGREG  = 8'hd8;
  localparam logic [7:0] B_MODREG  = 8'hc0;
  localparam logic [7:0] B_MODD8   = 8'h40;
  localparam logic [7:0] B_MODD32  = 8'h80;

  typedef struct packed {
    logic [4:0]         mode;
    logic               dest_kind;
    logic [1:0]         src_kind;
    logic               dest_wide;
    logic               src_wide;
    logic               base_wide;
    logic [2:0]         dest_reg;
    logic [2:0]         src_reg;
    logic [2:0]         base_reg;
    logic signed [31:0] displacement;
    logic               negate_offset;
    logic signed [63:0] immediate;
  } in_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       is_last;
    logic [1:0] status;
  } out_t;

  // register-form opcode of the two-operand group
  function automatic logic [7:0] alu_opcode(input logic [4:0] m);
    logic [7:0] r;
    unique case (m)
      5'd0:    r = 8'h89;
      5'd1:    r = 8'h8d;
      5'd2:    r = 8'h01;
      5'd3:    r = 8'h11;
      5'd4:    r = 8'h29;
      5'd5:    r = 8'h19;
      5'd6:    r = 8'h39;
      5'd7:    r = 8'h21;
      5'd8:    r = 8'h09;
      5'd9:    r = 8'h31;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // /digit extension for the immediate forms
  function automatic logic [2:0] alu_ext(input logic [4:0] m);
    logic [2:0] r;
    unique case (m)
      5'd3:    r = 3'd2;
      5'd4:    r = 3'd5;
      5'd5:    r = 3'd3;
      5'd6:    r = 3'd7;
      5'd7:    r = 3'd4;
      5'd8:    r = 3'd1;
      5'd9:    r = 3'd6;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/x86_64_instruction_encoder.sv
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder
// Encodes one resolved instruction into its machine-code bytes, one per word.
// ----------------------------------------------------------------------------
// the instruction is held in the input register, encoded combinationally and
//   loaded into the byte buffer, which gives out its bytes (1..11) in order
//   on the one-byte output port; the next instruction can wait in the input
//   register while the buffer drains, and one with no bytes skips the buffer
// reset: rst_n low clears the input and byte-buffer valid flags
`default_nettype none

module x86_64_instruction_encoder (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire x86enc_pkg::in_t    in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output x86enc_pkg::out_t        out_data
);
  import x86enc_pkg::*;

  // input register
  logic s1_valid_r, s1_valid_nxt;
  in_t  s1_r;

  // byte buffer, shifted down one byte per word taken
  logic                  s2_valid_r, s2_valid_nxt;
  logic [8*MaxBytes-1:0] buf_r, buf_nxt;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic [1:0]            st_r, st_nxt;

  // encoder outputs
  logic [8*MaxBytes-1:0] enc_buf;
  logic [CntW-1:0]       enc_n;
  logic [1:0]            enc_st;

  logic in_acc, s1_adv, s2_free, s2_load, out_take;

  // ---------------------------------------------------------------- encoder
  always_comb begin
    logic [32:0]   disp;
    logic          d8, i8, s8;
    logic          rex, has_mem;
    logic [1:0]    nob;
    logic [7:0]    ob0, ob1, op;
    logic [2:0]    regf, ext;
    logic [3:0]    imm_len;
    logic [CntW-1:0] p;
    logic [7:0]    b [MaxBytes];

    disp = {s1_r.displacement[31], s1_r.displacement};
    if (s1_r.negate_offset) begin
      disp = 33'd0 - disp;
    end
    d8 = (&disp[32:7]) | ~(|disp[32:7]);
    i8 = (&s1_r.immediate[63:7]) | ~(|s1_r.immediate[63:7]);
    op  = alu_opcode(s1_r.mode);
    ext = alu_ext(s1_r.mode);

    enc_st  = ST_OK;
    rex     = 1'b0;
    has_mem = 1'b0;
    nob     = 2'd0;
    ob0     = 8'h00;
    ob1     = 8'h00;
    regf    = 3'd0;
    imm_len = 4'd0;
    s8      = 1'b0;

    if (s1_r.mode <= OP_XOR) begin
      if (s1_r.dest_kind == KIND_REG) begin
        if (s1_r.src_kind == SRC_MEM) begin
          if (s1_r.dest_wide != s1_r.src_wide) begin
            enc_st = ST_SIZE;
          end else if (!s1_r.base_wide) begin
            enc_st = ST_BASE;
          end
        end
        rex = s1_r.dest_wide;
        case (s1_r.src_kind)
          SRC_REG: begin
            nob = 2'd2;
            ob0 = op;
            ob1 = B_MODREG | {2'b00, s1_r.src_reg, s1_r.dest_reg};
          end
          SRC_MEM: begin
            nob     = 2'd1;
            ob0     = (s1_r.mode == OP_LEA) ? op : (op | 8'h02);
            has_mem = 1'b1;
            regf    = s1_r.dest_reg;
          end
          SRC_IMM: begin
            if (s1_r.mode == OP_MOV) begin
              nob     = 2'd1;
              ob0     = B_MOVRI + {5'd0, s1_r.dest_reg};
              imm_len = s1_r.dest_wide ? 4'd8 : 4'd4;
            end else begin
              nob     = 2'd2;
              ob0     = i8 ? B_IMM8 : B_IMM32;
              ob1     = B_MODREG | {2'b00, ext, s1_r.dest_reg};
              imm_len = i8 ? 4'd1 : 4'd4;
            end
          end
          default: begin
          end
        endcase
      end else begin
        if (!s1_r.base_wide) begin
          enc_st = ST_BASE;
        end else if (s1_r.src_kind == SRC_REG && s1_r.dest_wide != s1_r.src_wide) begin
          enc_st = ST_SIZE;
        end
        rex = s1_r.dest_wide;
        if (s1_r.src_kind == SRC_REG) begin
          nob     = 2'd1;
          ob0     = op;
          has_mem = 1'b1;
          regf    = s1_r.src_reg;
        end else if (s1_r.src_kind == SRC_IMM) begin
          s8      = (s1_r.mode != OP_MOV) && i8;
          nob     = 2'd1;
          ob0     = (s1_r.mode == OP_MOV) ? B_MOVMI : (s8 ? B_IMM8 : B_IMM32);
          has_mem = 1'b1;
          regf    = ext;
          imm_len = s8 ? 4'd1 : 4'd4;
        end
      end
    end else begin
      unique case (s1_r.mode)
        OP_NEG: begin
          if (s1_r.dest_kind == KIND_MEM && !s1_r.base_wide) begin
            enc_st = ST_BASE;
          end
          rex = s1_r.dest_wide;
          ob0 = B_GRP3;
          if (s1_r.dest_kind == KIND_REG) begin
            nob = 2'd2;
            ob1 = B_NEGREG | {5'd0, s1_r.dest_reg};
          end else begin
            nob     = 2'd1;
            has_mem = 1'b1;
            regf    = 3'd3;
          end
        end
        OP_PUSH, OP_POP: begin
          if (!s1_r.dest_wide) begin
            enc_st = ST_STACK_SZ;
          end
          nob = 2'd1;
          ob0 = ((s1_r.mode == OP_PUSH) ? B_PUSH : B_POP) + {5'd0, s1_r.dest_reg};
        end
        OP_NOP: begin
          nob = 2'd1;
          ob0 = B_NOP;
        end
        OP_SYSCALL: begin
          nob = 2'd2;
          ob0 = B_ESC;
          ob1 = B_SYSCALL;
        end
        OP_CDQ: begin
          nob = 2'd1;
          ob0 = B_CDQ;
        end
        OP_CQO: begin
          rex = 1'b1;
          nob = 2'd1;
          ob0 = B_CDQ;
        end
        OP_LEAVE: begin
          nob = 2'd1;
          ob0 = B_LEAVE;
        end
        OP_RET: begin
          nob = 2'd1;
          ob0 = B_RET;
        end
        OP_RET_IMM: begin
          nob     = 2'd1;
          ob0     = B_RETI;
          imm_len = 4'd2;
        end
        default: begin
        end
      endcase
    end

    // lay the fields out in order
    for (int k = 0; k < MaxBytes; k++) begin
      b[k] = 8'h00;
    end
    p = '0;
    if (rex) begin
      b[p] = B_REXW;
      p    = p + 1'b1;
    end
    if (nob != 2'd0) begin
      b[p] = ob0;
      p    = p + 1'b1;
    end
    if (nob == 2'd2) begin
      b[p] = ob1;
      p    = p + 1'b1;
    end
    if (has_mem) begin
      b[p] = (d8 ? B_MODD8 : B_MODD32) | {2'b00, regf, s1_r.base_reg};
      p    = p + 1'b1;
      for (int k = 0; k < 4; k++) begin
        if (k == 0 || !d8) begin
          b[p + CntW'(k)] = disp[8*k +: 8];
        end
      end
      p = p + (d8 ? CntW'(1) : CntW'(4));
    end
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < imm_len) begin
        b[p + CntW'(k)] = s1_r.immediate[8*k +: 8];
      end
    end
    p = p + CntW'(imm_len);

    for (int k = 0; k < MaxBytes; k++) begin
      enc_buf[8*k +: 8] = b[k];
    end
    enc_n = p;
    if (enc_st != ST_OK) begin
      enc_buf = '0;
      enc_n   = CntW'(1);
    end
  end

  // ---------------------------------------------------------------- handshake
  assign out_take = s2_valid_r && !out_stall;
  assign s2_free  = !s2_valid_r || (out_take && cnt_r == CntW'(1));
  assign s1_adv   = s1_valid_r && ((enc_n == '0) || s2_free);
  assign s2_load  = s1_adv && (enc_n != '0);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    buf_nxt      = buf_r;
    cnt_nxt      = cnt_r;
    st_nxt       = st_r;
    if (s2_load) begin
      s2_valid_nxt = 1'b1;
      buf_nxt      = enc_buf;
      cnt_nxt      = enc_n;
      st_nxt       = enc_st;
    end else if (out_take) begin
      s2_valid_nxt = (cnt_r != CntW'(1));
      buf_nxt      = {8'h00, buf_r[8*MaxBytes-1:8]};
      cnt_nxt      = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_data;
    end
    buf_r <= buf_nxt;
    cnt_r <= cnt_nxt;
    st_r  <= st_nxt;
  end

  assign out_valid          = s2_valid_r;
  assign out_data.code_byte = buf_r[7:0];
  assign out_data.is_last   = (cnt_r == CntW'(1));
  assign out_data.status    = st_r;

endmodule

`default_nettype wire
